// ===== rtl/mdmf_pkg.sv =====
// Shared types and constants of the masked disk maximum filter.
`default_nettype none
package mdmf_pkg;

	localparam int PIX_W = 16;
	localparam int W_W = 11;
	localparam int H_W = 13;
	localparam int RSQ_W = 6;
	localparam int SQ_W = 12;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_RADIUS_DEF = 7;
	localparam int PIXEL_BITS_DEF = 16;

	localparam logic [W_W-1:0] WIDTH_RST = W_W'(1024);
	localparam logic [H_W-1:0] HEIGHT_RST = H_W'(1024);
	localparam logic [RSQ_W-1:0] RSQ_RST = RSQ_W'(1);

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_RADIUS_SQ = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_DRAIN,
		S_REDUCE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic shift;
		logic capture;
		logic clear;
		logic reduce;
		logic [SQ_W-1:0] dr_sq;
		logic [SQ_W-1:0] rsq;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/mdmf_in_if.sv =====
// Input channel carrying pixel and flush items.
`default_nettype none
interface mdmf_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [mdmf_pkg::PIX_W-1:0] in_pixel;
	logic in_mask;
	modport source(output valid, output op, output in_pixel, output in_mask, input ready);
	modport sink(input valid, input op, input in_pixel, input in_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/mdmf_out_if.sv =====
// Output channel carrying filter results.
`default_nettype none
interface mdmf_out_if;
	logic valid;
	logic ready;
	logic [mdmf_pkg::PIX_W-1:0] out_value;
	logic out_last;
	modport source(output valid, output out_value, output out_last, input ready);
	modport sink(input valid, input out_value, input out_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/mdmf_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mdmf_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/mdmf_cell.sv =====
// One window column cell: holds a row pixel and a running maximum.
`default_nettype none
module mdmf_cell #(
	parameter int PIXEL_BITS = 16,
	parameter int DC_SQ = 0
) (
	input  logic                   clk,
	input  mdmf_pkg::cell_ctrl_t   ctrl,
	input  logic [PIXEL_BITS-1:0]  in_pix,
	input  logic                   in_vld,
	input  logic [PIXEL_BITS-1:0]  nbr_best,
	output logic [PIXEL_BITS-1:0]  out_pix,
	output logic                   out_vld,
	output logic [PIXEL_BITS-1:0]  best
);
	import mdmf_pkg::*;

	logic [PIXEL_BITS-1:0] pix_q;
	logic vld_q;
	logic [PIXEL_BITS-1:0] best_q;
	logic [SQ_W:0] dist_sq;
	logic in_disk;

	assign dist_sq = {1'b0, ctrl.dr_sq} + (SQ_W+1)'(DC_SQ);
	assign in_disk = dist_sq <= {1'b0, ctrl.rsq};

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			pix_q <= in_pix;
			vld_q <= in_vld;
		end
		if (ctrl.clear) begin
			best_q <= '0;
		end else if (ctrl.capture && vld_q && in_disk && pix_q > best_q) begin
			best_q <= pix_q;
		end else if (ctrl.reduce && nbr_best > best_q) begin
			best_q <= nbr_best;
		end
	end

	assign out_pix = pix_q;
	assign out_vld = vld_q;
	assign best = best_q;
endmodule
`default_nettype wire

// ===== rtl/masked_disk_max_filter.sv =====
// Top level of the masked grey dilation filter over a disk neighborhood.
//
// Pixels arrive in raster order on pix_in, one transfer per item; op selects
// a pixel or a flush item. Each pixel of the frame is stored in a line store RAM. Once
// MAX_RADIUS rows plus MAX_RADIUS pixels beyond an output position are held,
// or the frame input is complete, one result leaves on res_out.
// A result is computed by reading the (2R+1) x (2R+1) window, R = MAX_RADIUS,
// one RAM word per cycle into a chain of 2R+1 column cells, then folding the
// cell maxima along the chain. An item that yields a result passes through the
// check, read, drain and reduce steps before the result register; the window
// reads are paced by the single RAM read port. An item with no result returns
// to idle after the check. Items are handled one at a time.
// A finished result waits in an output register while the next item is taken;
// if the receiver stalls, the next result waits until that register is free.
// Reset clears all position counters and loads the default size and radius.
// Writes to the width or height registers restart the frame.
`default_nettype none
module masked_disk_max_filter #(
	parameter int MAX_WIDTH = mdmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = mdmf_pkg::MAX_RADIUS_DEF,
	parameter int PIXEL_BITS = mdmf_pkg::PIXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mdmf_in_if.sink                       pix_in,
	mdmf_out_if.source                    res_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdmf_pkg::ADDR_W-1:0]   paddr,
	input  logic [mdmf_pkg::DATA_W-1:0]   pwdata,
	output logic [mdmf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import mdmf_pkg::*;

	localparam int NC = 2*MAX_RADIUS+1;
	localparam int IW = $clog2(NC);
	localparam int AW = $clog2(2*MAX_RADIUS*MAX_WIDTH+2*MAX_RADIUS+1);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int LAGW = $clog2(MAX_RADIUS*MAX_WIDTH+MAX_RADIUS+2);
	localparam int RW = H_W+2;
	localparam int CW = WW+2;
	localparam int RSQ_MAX = MAX_RADIUS*MAX_RADIUS;

	logic [W_W-1:0] width_q;
	logic [H_W-1:0] height_q;
	logic [RSQ_W-1:0] rsq_q;
	logic cfg_wr;
	logic size_wr;

	logic [WW-1:0] w_use;
	logic [H_W-1:0] h_use;
	logic [LAGW-1:0] lag;

	logic [H_W-1:0] in_row_q;
	logic [WW-1:0] in_col_q;
	logic [H_W-1:0] out_row_q;
	logic [WW-1:0] out_col_q;
	logic [AW-1:0] wr_addr_q;
	logic [AW-1:0] out_addr_q;
	logic [LAGW-1:0] pending_q;

	state_t state_q, state_d;
	logic accept, wr_pix, complete, go, last_pos;
	logic in_ready, clr, iss, red, emit;

	logic [IW-1:0] i_q, j_q, cnt_q;
	logic [AW-1:0] row_base_q;
	logic [AW-1:0] rd_addr;
	logic signed [RW-1:0] rn;
	logic signed [CW-1:0] cn;
	logic in_img;
	logic [IW-1:0] dr_abs;
	logic [SQ_W-1:0] dr_sq;

	logic iss_s1, inimg_s1, rowend_s1, center_s1;
	logic [SQ_W-1:0] dr_sq_s1;
	logic cap_s2;
	logic [SQ_W-1:0] dr_sq_s2;
	logic mask_q;
	logic [PIXEL_BITS:0] rd_data;

	cell_ctrl_t ctrl;
	logic [PIXEL_BITS-1:0] pix_c [NC];
	logic vld_c [NC];
	logic [PIXEL_BITS-1:0] best_c [NC];

	logic out_valid_q;
	logic [PIX_W-1:0] out_value_q;
	logic out_last_q;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign size_wr = cfg_wr && (paddr[ADDR_W-1:2] == REG_IMAGE_WIDTH ||
		paddr[ADDR_W-1:2] == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			rsq_q <= RSQ_RST;
		end else if (cfg_wr) begin
			case (paddr[ADDR_W-1:2])
				REG_IMAGE_WIDTH: width_q <= pwdata[W_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[H_W-1:0];
				REG_RADIUS_SQ: rsq_q <= pwdata[RSQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_IMAGE_WIDTH: prdata = DATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = DATA_W'(height_q);
			REG_RADIUS_SQ: prdata = DATA_W'(rsq_q);
			default: prdata = '0;
		endcase
	end

	// Sizes in use.
	always_comb begin
		if (width_q == '0) begin
			w_use = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_use = WW'(MAX_WIDTH);
		end else begin
			w_use = WW'(width_q);
		end
		h_use = (height_q == '0) ? H_W'(1) : height_q;
		lag = LAGW'(MAX_RADIUS * int'(w_use) + MAX_RADIUS);
	end

	assign accept = pix_in.valid && in_ready;
	assign complete = in_row_q >= h_use;
	assign wr_pix = accept && !pix_in.op && !complete;
	assign go = complete || (pending_q > lag);
	assign last_pos = (out_row_q == h_use - H_W'(1)) && (out_col_q == w_use - WW'(1));

	// Position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			wr_addr_q <= '0;
			out_addr_q <= '0;
			pending_q <= '0;
		end else if (size_wr || (emit && last_pos)) begin
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			wr_addr_q <= '0;
			out_addr_q <= '0;
			pending_q <= '0;
		end else begin
			if (wr_pix) begin
				wr_addr_q <= wr_addr_q + AW'(1);
				pending_q <= pending_q + LAGW'(1);
				if (in_col_q == w_use - WW'(1)) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + H_W'(1);
				end else begin
					in_col_q <= in_col_q + WW'(1);
				end
			end
			if (emit) begin
				out_addr_q <= out_addr_q + AW'(1);
				pending_q <= pending_q - LAGW'(1);
				if (out_col_q == w_use - WW'(1)) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + H_W'(1);
				end else begin
					out_col_q <= out_col_q + WW'(1);
				end
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_CHECK;
			S_CHECK: state_d = go ? S_READ : S_IDLE;
			S_READ: if (i_q == IW'(NC-1) && j_q == IW'(NC-1)) state_d = S_DRAIN;
			S_DRAIN: if (cnt_q == IW'(1)) state_d = S_REDUCE;
			S_REDUCE: if (cnt_q == IW'(2*MAX_RADIUS-1)) state_d = S_EMIT;
			S_EMIT: if (emit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		clr = 1'b0;
		iss = 1'b0;
		red = 1'b0;
		emit = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_CHECK: clr = go;
			S_READ: iss = 1'b1;
			S_REDUCE: red = 1'b1;
			S_EMIT: emit = !out_valid_q || res_out.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			row_base_q <= '0;
		end else begin
			case (state_q)
				S_CHECK: begin
					i_q <= '0;
					j_q <= '0;
					cnt_q <= '0;
					row_base_q <= out_addr_q - AW'(lag);
				end
				S_READ: begin
					cnt_q <= '0;
					if (j_q == IW'(NC-1)) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
						row_base_q <= row_base_q + AW'(w_use);
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				S_DRAIN: cnt_q <= (cnt_q == IW'(1)) ? '0 : cnt_q + IW'(1);
				S_REDUCE: cnt_q <= cnt_q + IW'(1);
				default: ;
			endcase
		end
	end

	// Window read addressing and border test.
	assign rd_addr = row_base_q + AW'(j_q);
	assign rn = $signed({2'b00, out_row_q}) + $signed(RW'(i_q)) - $signed(RW'(MAX_RADIUS));
	assign cn = $signed({2'b00, out_col_q}) + $signed(CW'(j_q)) - $signed(CW'(MAX_RADIUS));
	assign in_img = !rn[RW-1] && (rn < $signed({2'b00, h_use})) &&
		!cn[CW-1] && (cn < $signed({2'b00, w_use}));
	assign dr_abs = (i_q >= IW'(MAX_RADIUS)) ? i_q - IW'(MAX_RADIUS) : IW'(MAX_RADIUS) - i_q;
	assign dr_sq = SQ_W'(dr_abs) * SQ_W'(dr_abs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= 1'b0;
			rowend_s1 <= 1'b0;
			center_s1 <= 1'b0;
			cap_s2 <= 1'b0;
		end else begin
			iss_s1 <= iss;
			rowend_s1 <= iss && (j_q == IW'(NC-1));
			center_s1 <= iss && (i_q == IW'(MAX_RADIUS)) && (j_q == IW'(MAX_RADIUS));
			cap_s2 <= iss_s1 && rowend_s1;
		end
	end

	always_ff @(posedge clk) begin
		inimg_s1 <= in_img;
		dr_sq_s1 <= dr_sq;
		dr_sq_s2 <= dr_sq_s1;
		if (center_s1) begin
			mask_q <= rd_data[PIXEL_BITS];
		end
	end

	mdmf_ram #(
		.WIDTH(PIXEL_BITS+1),
		.DEPTH(2**AW)
	) u_line_store (
		.clk(clk),
		.we(wr_pix),
		.waddr(wr_addr_q),
		.wdata({pix_in.in_mask, pix_in.in_pixel[PIXEL_BITS-1:0]}),
		.re(iss),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Column cell chain.
	assign ctrl.shift = iss_s1;
	assign ctrl.capture = cap_s2;
	assign ctrl.clear = clr;
	assign ctrl.reduce = red;
	assign ctrl.dr_sq = dr_sq_s2;
	assign ctrl.rsq = (int'(rsq_q) > RSQ_MAX) ? SQ_W'(RSQ_MAX) : SQ_W'(rsq_q);

	for (genvar k = 0; k < NC; k++) begin : g_cell
		localparam int DC = MAX_RADIUS - k;
		logic [PIXEL_BITS-1:0] in_pix;
		logic in_vld;
		logic [PIXEL_BITS-1:0] nbr;
		if (k == 0) begin : g_head
			assign in_pix = rd_data[PIXEL_BITS-1:0];
			assign in_vld = inimg_s1;
		end else begin : g_body
			assign in_pix = pix_c[k-1];
			assign in_vld = vld_c[k-1];
		end
		if (k == NC-1) begin : g_tail
			assign nbr = '0;
		end else begin : g_next
			assign nbr = best_c[k+1];
		end
		mdmf_cell #(
			.PIXEL_BITS(PIXEL_BITS),
			.DC_SQ(DC*DC)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.in_pix(in_pix),
			.in_vld(in_vld),
			.nbr_best(nbr),
			.out_pix(pix_c[k]),
			.out_vld(vld_c[k]),
			.best(best_c[k])
		);
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= mask_q ? PIX_W'(best_c[0]) : '0;
			out_last_q <= last_pos;
		end
	end

	assign pix_in.ready = in_ready;
	assign res_out.valid = out_valid_q;
	assign res_out.out_value = out_value_q;
	assign res_out.out_last = out_last_q;

	// The received-but-unreported count never runs more than one past the lag before the frame completes.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!complete |-> ({1'b0, pending_q} <= {1'b0, lag} + (LAGW+1)'(1)))
		else $error("pending count exceeds lag");

	// Row captures only occur while the window is being read or drained.
	a_capture_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cap_s2 |-> (state_q == S_READ || state_q == S_DRAIN))
		else $error("row capture outside read phase");

	// A result is only produced for a position inside the frame.
	a_emit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (out_row_q < h_use && out_col_q < w_use))
		else $error("result position outside frame");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the masked disk maximum filter, with its scoreboard class.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mdmf_pkg::*;

	localparam int RAD = MAX_RADIUS_DEF;
	localparam int MAXW = MAX_WIDTH_DEF;
	localparam int STORE_DEPTH = 2 * RAD * MAXW + 2 * RAD + 1;
	localparam int SETTLE = 300;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [PIX_W-1:0] value;
		logic last;
	} dilate_res_t;

	class dilate_board;
		logic [PIX_W:0] store [STORE_DEPTH];
		int unsigned in_r, in_c, out_r, out_c;
		int unsigned width_reg, height_reg, rsq_reg;
		dilate_res_t expected [$];
		int mismatches;

		function new();
			width_reg = 1024;
			height_reg = 1024;
			rsq_reg = 1;
			mismatches = 0;
			clear_pos();
		endfunction

		function void clear_pos();
			in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		endfunction

		function int unsigned w_use();
			if (width_reg == 0) return 1;
			return (width_reg > MAXW) ? MAXW : width_reg;
		endfunction

		function int unsigned h_use();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void set_reg(reg_idx_t idx, int unsigned val);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = val & 11'h7FF;
					clear_pos();
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = val & 13'h1FFF;
					clear_pos();
				end
				REG_RADIUS_SQ: rsq_reg = val & 6'h3F;
				default: ;
			endcase
		endfunction

		function int unsigned frame_left();
			return h_use() * w_use() - (out_r * w_use() + out_c);
		endfunction

		function logic [PIX_W-1:0] disk_peak(int unsigned w, int unsigned h);
			int rn, cn;
			int unsigned lim;
			logic [PIX_W-1:0] best;
			lim = (rsq_reg > RAD * RAD) ? RAD * RAD : rsq_reg;
			best = '0;
			for (int dr = -RAD; dr <= RAD; dr++) begin
				rn = int'(out_r) + dr;
				if (rn < 0 || rn >= int'(h)) continue;
				for (int dc = -RAD; dc <= RAD; dc++) begin
					cn = int'(out_c) + dc;
					if (cn < 0 || cn >= int'(w)) continue;
					if (dr * dr + dc * dc > int'(lim)) continue;
					if (store[(rn * w + cn) % STORE_DEPTH][PIX_W-1:0] > best)
						best = store[(rn * w + cn) % STORE_DEPTH][PIX_W-1:0];
				end
			end
			return best;
		endfunction

		function void note_input(logic op, logic [PIX_W-1:0] pix, logic msk);
			int unsigned w, h, lag, in_lin, out_lin;
			bit done;
			dilate_res_t r;
			w = w_use();
			h = h_use();
			lag = RAD * w + RAD;
			done = in_r >= h;
			if (!op && !done) begin
				store[(in_r * w + in_c) % STORE_DEPTH] = {msk, pix};
				in_c++;
				if (in_c >= w) begin
					in_c = 0;
					in_r++;
				end
			end
			done = in_r >= h;
			in_lin = done ? h * w : in_r * w + in_c;
			out_lin = out_r * w + out_c;
			if (!done && in_lin <= out_lin + lag) return;
			r.value = store[out_lin % STORE_DEPTH][PIX_W] ? disk_peak(w, h) : '0;
			r.last = (out_r == h - 1) && (out_c == w - 1);
			expected.push_back(r);
			if (r.last) begin
				clear_pos();
			end else begin
				out_c++;
				if (out_c >= w) begin
					out_c = 0;
					out_r++;
				end
			end
		endfunction

		function void check_result(logic [PIX_W-1:0] value, logic last);
			dilate_res_t e;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result value=%h last=%b", value, last);
				return;
			end
			e = expected.pop_front();
			if (value !== e.value || last !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected value=%h last=%b, got value=%h last=%b",
						e.value, e.last, value, last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	longint cycles = 0;
	int burst_left = 0;
	int rx_left = 0;
	int rx_mode = 0;
	int items = 0;
	dilate_board board = new();

	mdmf_in_if pin();
	mdmf_out_if rout();

	masked_disk_max_filter dut (
		.clk(clk), .arst_n(arst_n), .pix_in(pin), .res_out(rout),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && rout.valid && rout.ready)
			board.check_result(rout.out_value, rout.out_last);

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(10, 200);
		end
		rx_left--;
		case (rx_mode)
			0: rout.ready = 1'b1;
			1: rout.ready = $urandom_range(0, 1);
			default: rout.ready = ($urandom_range(0, 15) == 0);
		endcase
	end

	task automatic send(logic op, logic [PIX_W-1:0] pix, logic msk);
		if (burst_left == 0) begin
			int gap = $urandom_range(0, 8);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				pin.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pin.valid = 1'b1;
		pin.op = op;
		pin.in_pixel = pix;
		pin.in_mask = msk;
		@(posedge clk);
		while (!pin.ready) @(posedge clk);
		board.note_input(op, pix, msk);
		items++;
		@(negedge clk);
	endtask

	task automatic settle();
		pin.valid = 1'b0;
		while (board.expected.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, int unsigned val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic setup(int unsigned w, int unsigned h, int unsigned rsq);
		settle();
		reg_write(REG_IMAGE_WIDTH, w);
		reg_write(REG_IMAGE_HEIGHT, h);
		reg_write(REG_RADIUS_SQ, rsq);
	endtask

	function automatic logic [PIX_W-1:0] rand_pix();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	// Streams a frame; a nonzero stop_after cuts it to at most that many pixels.
	task automatic run_frame(int stop_after, bit noise);
		int n;
		n = board.w_use() * board.h_use();
		if (stop_after > 0 && stop_after < n) n = stop_after;
		for (int i = 0; i < n; i++) begin
			if (noise && $urandom_range(0, 9) == 0)
				send(1'b1, rand_pix(), $urandom_range(0, 1));
			send(1'b0, rand_pix(), $urandom_range(0, 3) != 0);
		end
		if (stop_after > 0) return;
		n = board.frame_left();
		for (int i = 0; i < n; i++)
			send($urandom_range(0, 2) != 0, rand_pix(), $urandom_range(0, 1));
	endtask

	initial begin
		pin.valid = 1'b0;
		pin.op = 1'b0;
		pin.in_pixel = '0;
		pin.in_mask = 1'b0;
		rout.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(1'b1, '0, 1'b0);
		setup(1, 1, 0);
		send(1'b0, 16'hFFFF, 1'b1);
		send(1'b0, 16'h1234, 1'b1);
		setup(3, 3, 63);
		send(1'b1, '0, 1'b1);
		send(1'b0, 16'hFFFF, 1'b1);
		send(1'b0, 16'h0000, 1'b1);
		send(1'b0, 16'h8001, 1'b0);
		for (int i = 0; i < 6; i++) send(1'b0, 16'h5555 << i, 1'b1);
		for (int i = 0; i < 9; i++) send(i[0], 16'hAAAA, 1'b0);
		setup(0, 0, 49);
		run_frame(0, 1'b0);
		setup(1, 4096, 2);
		run_frame(20, 1'b1);
		setup(2047, 1, 49);
		run_frame(30, 1'b0);

		while (items < 620) begin
			if ($urandom_range(0, 3) == 0) begin
				settle();
				reg_write(REG_RADIUS_SQ, $urandom_range(0, 63));
			end else begin
				setup(($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8),
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 5),
					$urandom_range(0, 63));
			end
			run_frame(($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0, 1'b1);
		end

		settle();
		if (board.mismatches == 0 && board.expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== masked_disk_max_filter.f =====
rtl/mdmf_pkg.sv
rtl/mdmf_in_if.sv
rtl/mdmf_out_if.sv
rtl/mdmf_ram.sv
rtl/mdmf_cell.sv
rtl/masked_disk_max_filter.sv
bench/tb_top.sv
